/* hdl/mdr_pkg.sv */
// mdr_pkg: shared types and constants for the rounded multiply-divide block
// holds status codes, controller states and the command/status structs
// no dependencies
package mdr_pkg;

   localparam int FIELD_BITS  = 64;
   localparam int STATUS_BITS = 2;
   localparam int DIGIT_BITS  = 16;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic round;
      logic prep;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic hi_lt_c;
   } sts_type;

endpackage

/* hdl/mdr_ctrl.sv */
// mdr_ctrl: sequencer for the multiply, rounding and division phases
// drives datapath commands, start/busy handshake and the result strobe
// depends on mdr_pkg
module mdr_ctrl #(
   parameter int OPERAND_BITS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output mdr_pkg::cmd_type  cmd,
   input  mdr_pkg::sts_type  sts
);
   import mdr_pkg::*;

   localparam int NDIG     = (OPERAND_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int CNT_BITS = $clog2(2 * OPERAND_BITS);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == CNT_BITS'(NDIG - 1)) begin
               cnt_in   = '0;
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            // high half below divisor: quotient high half is zero, skip its steps
            if (sts.hi_lt_c) begin
               cnt_in = CNT_BITS'(OPERAND_BITS - 1);
            end else begin
               cnt_in = CNT_BITS'(2 * OPERAND_BITS - 1);
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/mdr_datapath.sv */
// mdr_datapath: operand registers, digit-serial multiplier, rounding adder,
// restoring divider and result registers
// depends on mdr_pkg; sequenced by mdr_ctrl
module mdr_datapath #(
   parameter int OPERAND_BITS = 64
) (
   input  logic                                clock,
   input  logic [mdr_pkg::FIELD_BITS-1:0]      req_a,
   input  logic [mdr_pkg::FIELD_BITS-1:0]      req_b,
   input  logic [mdr_pkg::FIELD_BITS-1:0]      req_c,
   input  logic                                req_round_up,
   input  logic                                req_signed_limit,
   input  mdr_pkg::cmd_type                    cmd,
   output mdr_pkg::sts_type                    sts,
   output logic [mdr_pkg::FIELD_BITS-1:0]      rsp_quotient,
   output logic [mdr_pkg::STATUS_BITS-1:0]     rsp_status
);
   import mdr_pkg::*;

   localparam int W    = OPERAND_BITS;
   localparam int NDIG = (W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int BW   = NDIG * DIGIT_BITS;
   localparam int PW   = W + BW;

   logic [W-1:0]           a_ff, a_in;
   logic [W-1:0]           c_ff, c_in;
   logic                   up_ff, up_in;
   logic                   lim_ff, lim_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [2*W-1:0]         num_ff, num_in;
   logic [W-1:0]           rem_ff, rem_in;
   logic [FIELD_BITS-1:0]  quot_ff, quot_in;
   logic [STATUS_BITS-1:0] stat_ff, stat_in;

   logic [W+DIGIT_BITS-1:0]    part;
   logic [W+DIGIT_BITS-1:0]    acc;
   logic [PW+DIGIT_BITS-1:0]   joined;
   logic [W-1:0]               add_val;
   logic [2*W-1:0]             sum;
   logic [W:0]                 shifted;
   logic [W:0]                 diff;
   logic                       take;
   logic [W-1:0]               qlo;
   logic                       ovf;

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      c_ff    <= c_in;
      up_ff   <= up_in;
      lim_ff  <= lim_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      stat_ff <= stat_in;
   end

   // multiply: one 16-bit digit of b per beat, accumulator shifts right
   assign part   = a_ff * prod_ff[DIGIT_BITS-1:0];
   assign acc    = (W + DIGIT_BITS)'(prod_ff[PW-1:BW]) + part;
   assign joined = {acc, prod_ff[BW-1:0]};

   assign add_val = up_ff ? (c_ff - 1'b1) : '0;
   assign sum     = prod_ff[2*W-1:0] + (2 * W)'(add_val);

   // restoring division step, remainder gets one extra bit for the shifted-out top
   assign shifted = {rem_ff, num_ff[2*W-1]};
   assign diff    = shifted - (W + 1)'(c_ff);
   assign take    = (shifted >= (W + 1)'(c_ff));

   assign qlo = num_ff[W-1:0];
   assign ovf = (|num_ff[2*W-1:W]) | (lim_ff & qlo[W-1]);

   always_comb begin
      a_in    = a_ff;
      c_in    = c_ff;
      up_in   = up_ff;
      lim_in  = lim_ff;
      prod_in = prod_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      stat_in = stat_ff;
      if (cmd.load) begin
         a_in    = req_a[W-1:0];
         c_in    = req_c[W-1:0];
         up_in   = req_round_up;
         lim_in  = req_signed_limit;
         prod_in = PW'(req_b[W-1:0]);
      end
      if (cmd.mul_step) begin
         prod_in = PW'(joined >> DIGIT_BITS);
      end
      if (cmd.round) begin
         num_in = sum;
      end
      if (cmd.prep) begin
         if (sts.hi_lt_c) begin
            rem_in = num_ff[2*W-1:W];
            num_in = {num_ff[W-1:0], {W{1'b0}}};
         end else begin
            rem_in = '0;
         end
      end
      if (cmd.div_step) begin
         rem_in = take ? diff[W-1:0] : shifted[W-1:0];
         num_in = {num_ff[2*W-2:0], take};
      end
      if (cmd.finish) begin
         if (c_ff == '0) begin
            quot_in = '0;
            stat_in = STATUS_DIV_ZERO;
         end else begin
            quot_in = FIELD_BITS'(qlo);
            stat_in = ovf ? STATUS_OVERFLOW : STATUS_OK;
         end
      end
   end

   assign sts.hi_lt_c  = (num_ff[2*W-1:W] < c_ff);
   assign rsp_quotient = quot_ff;
   assign rsp_status   = stat_ff;

endmodule

/* hdl/mul_div_round_64.sv */
// mul_div_round_64: top level of the rounded (a*b)/c unit
// joins mdr_ctrl and mdr_datapath; depends on mdr_pkg
//
//   channel   ports                                        handshake
//   request   req_a req_b req_c req_round_up               start & !busy
//             req_signed_limit
//   response  rsp_quotient rsp_status                      rsp_valid, one cycle
//
// the sequence runs ceil(W/16) multiply digits, a rounding step and a prep step, then the
// one-bit-per-beat divider: W steps when the high half of the rounded product is below c,
// otherwise 2*W (W = OPERAND_BITS)
// busy drops in the cycle rsp_valid is shown, so the next start is taken then
// one item at a time; synchronous reset clears the sequencer and strobe only
// results cannot be held off: the receiver must take rsp_valid when it comes
module mul_div_round_64 #(
   parameter int OPERAND_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mdr_pkg::FIELD_BITS-1:0]      req_a,
   input  logic [mdr_pkg::FIELD_BITS-1:0]      req_b,
   input  logic [mdr_pkg::FIELD_BITS-1:0]      req_c,
   input  logic                                req_round_up,
   input  logic                                req_signed_limit,
   output logic                                rsp_valid,
   output logic [mdr_pkg::FIELD_BITS-1:0]      rsp_quotient,
   output logic [mdr_pkg::STATUS_BITS-1:0]     rsp_status
);
   import mdr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mdr_ctrl #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   mdr_datapath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_datapath (
      .clock            (clock),
      .req_a            (req_a),
      .req_b            (req_b),
      .req_c            (req_c),
      .req_round_up     (req_round_up),
      .req_signed_limit (req_signed_limit),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_quotient     (rsp_quotient),
      .rsp_status       (rsp_status)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted beat");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer still busy");

   a_div_zero_quot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DIV_ZERO) |-> (rsp_quotient == '0))
      else $error("nonzero quotient on zero divisor");

   a_load_once: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!cmd.mul_step && !cmd.div_step && !cmd.finish))
      else $error("operand load overlaps a working phase");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for mul_div_round_64, rounded (a*b)/c with status
// directed table then random beats, checked against stored results or a wide-integer predictor
// depends on mdr_pkg and the mul_div_round_64 rtl
module tb_top;
   import mdr_pkg::*;

   localparam int          OPERAND_BITS = 64;
   localparam int          RANDOM_BEATS = 1430;
   localparam int          DRAIN_CYCLES = 160;
   localparam int          LIMIT_CYCLES = 1_000_000;
   localparam logic [63:0] U64_MAX      = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] I64_MAX      = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] I64_MIN_MAG  = 64'h8000_0000_0000_0000;

   typedef struct {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic        round_up;
      logic        signed_limit;
      logic        known;
      logic [63:0] quotient;
      status_type  status;
   } mdr_row_type;

   typedef struct {
      logic [63:0] quotient;
      status_type  status;
   } quot_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_a = '0;
   logic [63:0] req_b = '0;
   logic [63:0] req_c = '0;
   logic        req_round_up = 1'b0;
   logic        req_signed_limit = 1'b0;
   logic        rsp_valid;
   logic [63:0] rsp_quotient;
   logic [1:0]  rsp_status;

   quot_result_type pending_quot[$];
   mdr_row_type     directed_rows[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   bit              idle_on = 1'b1;

   mul_div_round_64 #(
      .OPERAND_BITS(OPERAND_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_a           (req_a),
      .req_b           (req_b),
      .req_c           (req_c),
      .req_round_up    (req_round_up),
      .req_signed_limit(req_signed_limit),
      .rsp_valid       (rsp_valid),
      .rsp_quotient    (rsp_quotient),
      .rsp_status      (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] corner_value();
      case ($urandom_range(0, 6))
         0: return 64'd0;
         1: return 64'd1;
         2: return U64_MAX;
         3: return U64_MAX - 64'd1;
         4: return I64_MIN_MAG;
         5: return I64_MAX;
         default: return rnd64();
      endcase
   endfunction

   function automatic mdr_row_type mk_row(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                          logic round_up, logic signed_limit, logic known,
                                          logic [63:0] quotient, status_type status);
      mdr_row_type r;
      r.a = a;
      r.b = b;
      r.c = c;
      r.round_up = round_up;
      r.signed_limit = signed_limit;
      r.known = known;
      r.quotient = quotient;
      r.status = status;
      return r;
   endfunction

   // floor or ceiling of the full product over c, at OPERAND_BITS
   function automatic quot_result_type predict_muldiv(mdr_row_type r);
      logic [127:0] mask;
      logic [127:0] a;
      logic [127:0] b;
      logic [127:0] c;
      logic [127:0] num;
      logic [127:0] q;
      quot_result_type res;
      mask = (128'd1 << OPERAND_BITS) - 128'd1;
      a = {64'd0, r.a} & mask;
      b = {64'd0, r.b} & mask;
      c = {64'd0, r.c} & mask;
      if (c == 128'd0) begin
         res.quotient = '0;
         res.status = STATUS_DIV_ZERO;
         return res;
      end
      num = a * b;
      if (r.round_up)
         num = num + c - 128'd1;
      q = num / c;
      res.quotient = q[63:0] & mask[63:0];
      if (q > mask || (r.signed_limit && q > (mask >> 1)))
         res.status = STATUS_OVERFLOW;
      else
         res.status = STATUS_OK;
      return res;
   endfunction

   task automatic log_mismatch(string what, logic [63:0] expected, logic [63:0] actual);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at %0t: %s expected %h got %h", $realtime, what, expected, actual);
   endtask

   // entered at a falling edge, leaves at the falling edge after the beat is taken
   task automatic send_beat(mdr_row_type r);
      quot_result_type res;
      while (idle_on && $urandom_range(0, 99) < 29) begin
         start <= 1'b0;
         req_a <= rnd64();
         req_b <= rnd64();
         req_c <= rnd64();
         req_round_up <= 1'($urandom_range(0, 1));
         req_signed_limit <= 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      start <= 1'b1;
      req_a <= r.a;
      req_b <= r.b;
      req_c <= r.c;
      req_round_up <= r.round_up;
      req_signed_limit <= r.signed_limit;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (r.known) begin
         res.quotient = r.quotient;
         res.status = r.status;
      end else begin
         res = predict_muldiv(r);
      end
      pending_quot.push_back(res);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      quot_result_type head;
      if (!reset && rsp_valid) begin
         if (pending_quot.size() == 0) begin
            log_mismatch("unexpected result, quotient", 64'd0, rsp_quotient);
         end else begin
            head = pending_quot.pop_front();
            if (rsp_quotient !== head.quotient)
               log_mismatch("quotient", head.quotient, rsp_quotient);
            if (rsp_status !== head.status)
               log_mismatch("status", 64'(head.status), 64'(rsp_status));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      mdr_row_type r;
      int          mode;
      // known results
      directed_rows.push_back(mk_row(64'd0, 64'd0, 64'd1, 0, 0, 1, 64'd0, STATUS_OK));
      directed_rows.push_back(mk_row(U64_MAX, U64_MAX, U64_MAX, 0, 0, 1, U64_MAX, STATUS_OK));
      directed_rows.push_back(mk_row(U64_MAX, U64_MAX, U64_MAX, 0, 1, 1, U64_MAX,
                                     STATUS_OVERFLOW));
      directed_rows.push_back(mk_row(U64_MAX, U64_MAX, U64_MAX, 1, 0, 1, U64_MAX, STATUS_OK));
      // max squared has low half one
      directed_rows.push_back(mk_row(U64_MAX, U64_MAX, 64'd1, 0, 0, 1, 64'd1, STATUS_OVERFLOW));
      directed_rows.push_back(mk_row(U64_MAX, U64_MAX, 64'd0, 1, 1, 1, 64'd0, STATUS_DIV_ZERO));
      directed_rows.push_back(mk_row(64'd0, 64'd0, 64'd0, 0, 0, 1, 64'd0, STATUS_DIV_ZERO));
      directed_rows.push_back(mk_row(64'd1, 64'd1, 64'd2, 0, 0, 1, 64'd0, STATUS_OK));
      directed_rows.push_back(mk_row(64'd1, 64'd1, 64'd2, 1, 0, 1, 64'd1, STATUS_OK));
      directed_rows.push_back(mk_row(64'd0, 64'd0, U64_MAX, 1, 0, 1, 64'd0, STATUS_OK));
      directed_rows.push_back(mk_row(I64_MIN_MAG, 64'd1, 64'd1, 0, 1, 1, I64_MIN_MAG,
                                     STATUS_OVERFLOW));
      directed_rows.push_back(mk_row(I64_MAX, 64'd1, 64'd1, 0, 1, 1, I64_MAX, STATUS_OK));
      directed_rows.push_back(mk_row(I64_MIN_MAG, 64'd1, 64'd1, 0, 0, 1, I64_MIN_MAG,
                                     STATUS_OK));
      // predicted
      directed_rows.push_back(mk_row(64'd7, 64'd3, 64'd2, 1, 0, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(64'd7, 64'd3, 64'd2, 0, 0, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(U64_MAX, U64_MAX, U64_MAX - 64'd1, 1, 1, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'd3,
                                     1, 0, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                                     64'haaaa_aaaa_aaaa_aaaa, 0, 1, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(U64_MAX, 64'd2, 64'd1, 1, 0, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(I64_MIN_MAG, I64_MIN_MAG, I64_MIN_MAG + 64'd1, 1, 1, 0,
                                     '0, STATUS_OK));
      directed_rows.push_back(mk_row(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321,
                                     64'h0000_0100_0000_0000, 1, 0, 0, '0, STATUS_OK));
      directed_rows.push_back(mk_row(64'd1, U64_MAX, U64_MAX, 1, 1, 0, '0, STATUS_OK));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i]);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // a long run of back-to-back beats in the middle
         idle_on = !(n >= 600 && n < 900);
         r.a = rnd64();
         r.b = rnd64();
         r.c = rnd64();
         r.round_up = 1'($urandom_range(0, 1));
         r.signed_limit = 1'($urandom_range(0, 1));
         r.known = 1'b0;
         r.quotient = '0;
         r.status = STATUS_OK;
         mode = $urandom_range(0, 19);
         case (mode)
            0: r.c = '0;
            1, 2, 3: ;
            // b no larger than c keeps the quotient within a
            4, 5, 6, 7, 8, 9, 10: r.b = r.c >> $urandom_range(0, 12);
            11, 12, 13: begin
               r.a = r.a >> $urandom_range(0, 63);
               r.b = r.b >> $urandom_range(0, 63);
               r.c = r.c >> $urandom_range(0, 63);
            end
            14, 15: begin
               r.a = corner_value();
               r.b = corner_value();
               r.c = corner_value();
            end
            // quotient lands around the signed limit
            16, 17: begin
               r.b = r.c;
               r.a = I64_MIN_MAG + 64'($urandom_range(0, 4)) - 64'd2;
            end
            default: begin
               r.c = 64'($urandom_range(1, 1000));
               r.a = r.a >> $urandom_range(0, 63);
            end
         endcase
         send_beat(r);
      end
      start <= 1'b0;

      while (pending_quot.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_quot.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
